@@ hdl/ppr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the packed pixel to RGB888 unpacker.
// No dependencies; used by every module of the block.
package ppr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_RED_OFFSET   = 3'd0;
    localparam logic [2:0] REG_RED_LENGTH   = 3'd1;
    localparam logic [2:0] REG_GREEN_OFFSET = 3'd2;
    localparam logic [2:0] REG_GREEN_LENGTH = 3'd3;
    localparam logic [2:0] REG_BLUE_OFFSET  = 3'd4;
    localparam logic [2:0] REG_BLUE_LENGTH  = 3'd5;
    localparam logic [2:0] REG_PIXEL_SIZE   = 3'd6;

    localparam int NUM_CHAN   = 3;
    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;

    // Longest channel field that is still decoded
    localparam logic [4:0] MAX_LENGTH = 5'd16;

    // RGB565 layout used for two-byte pixels when no channel length is programmed
    localparam logic [4:0] RGB565_RED_OFF   = 5'd11;
    localparam logic [4:0] RGB565_RED_LEN   = 5'd5;
    localparam logic [4:0] RGB565_GREEN_OFF = 5'd5;
    localparam logic [4:0] RGB565_GREEN_LEN = 5'd6;
    localparam logic [4:0] RGB565_BLUE_OFF  = 5'd0;
    localparam logic [4:0] RGB565_BLUE_LEN  = 5'd5;

    // XRGB8888 layout for every other pixel size
    localparam logic [4:0] XRGB_RED_OFF   = 5'd16;
    localparam logic [4:0] XRGB_GREEN_OFF = 5'd8;
    localparam logic [4:0] XRGB_BLUE_OFF  = 5'd0;
    localparam logic [4:0] XRGB_LEN       = 5'd8;

    localparam logic [2:0] RGB565_BYTES = 3'd2;

    typedef struct packed {
        logic [5:0] red_offset;
        logic [4:0] red_length;
        logic [5:0] green_offset;
        logic [4:0] green_length;
        logic [5:0] blue_offset;
        logic [4:0] blue_length;
        logic [2:0] pixel_size_bytes;
    } cfg_t;

    // Resolved field of one channel after stage 1
    typedef struct packed {
        logic       zero;
        logic [4:0] offset;
        logic [4:0] length;
    } chan_t;

    // Cut-out field of one channel after stage 2
    typedef struct packed {
        logic        zero;
        logic [4:0]  length;
        logic [15:0] value;
    } cut_t;

endpackage

@@ hdl/packed_pixel_to_rgb888.sv @@
`timescale 1ns / 1ps
// Top level of the packed pixel to RGB888 unpacker: configuration registers,
// pipeline valid bits and handshake. Depends on ppr_pkg and the stage modules.
//
// One pixel is taken per clock and one RGB888 result leaves per clock while the
// output is not stalled. A pixel passes through byte masking and field choice,
// field cut-out, then widening into the output register that drives m_tdata. Each
// stage loads when it is empty or the stage after it moves on, so a stalled
// output fills the pipeline and then drops s_tready; nothing is lost or
// repeated. Write the configuration only while no pixel is in flight.
module packed_pixel_to_rgb888
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pixel_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    ppr_pkg::cfg_t  cfg_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic           en1;
    logic           en2;
    logic           en3;
    logic [31:0]    word_reg;
    ppr_pkg::chan_t chan_reg [ppr_pkg::NUM_CHAN];
    ppr_pkg::cut_t  cut_reg [ppr_pkg::NUM_CHAN];
    logic [7:0]     level_reg [ppr_pkg::NUM_CHAN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_offset       <= 6'd16;
            cfg_reg.red_length       <= 5'd0;
            cfg_reg.green_offset     <= 6'd8;
            cfg_reg.green_length     <= 5'd0;
            cfg_reg.blue_offset      <= 6'd0;
            cfg_reg.blue_length      <= 5'd0;
            cfg_reg.pixel_size_bytes <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppr_pkg::REG_RED_OFFSET:   cfg_reg.red_offset       <= cfg_data;
                ppr_pkg::REG_RED_LENGTH:   cfg_reg.red_length       <= cfg_data[4:0];
                ppr_pkg::REG_GREEN_OFFSET: cfg_reg.green_offset     <= cfg_data;
                ppr_pkg::REG_GREEN_LENGTH: cfg_reg.green_length     <= cfg_data[4:0];
                ppr_pkg::REG_BLUE_OFFSET:  cfg_reg.blue_offset      <= cfg_data;
                ppr_pkg::REG_BLUE_LENGTH:  cfg_reg.blue_length      <= cfg_data[4:0];
                ppr_pkg::REG_PIXEL_SIZE:   cfg_reg.pixel_size_bytes <= cfg_data[2:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor takes its contents
    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    ppr_chan_sel u_chan_sel
    (
        .clk        (clk),
        .en         (en1),
        .pixel_word (s_tdata),
        .cfg        (cfg_reg),
        .word_reg   (word_reg),
        .chan_reg   (chan_reg)
    );

    for (genvar c = 0; c < ppr_pkg::NUM_CHAN; c++)
    begin : g_chan
        ppr_field_cut u_field_cut
        (
            .clk     (clk),
            .en      (en2),
            .word    (word_reg),
            .chan    (chan_reg[c]),
            .cut_reg (cut_reg[c])
        );

        ppr_widen u_widen
        (
            .clk       (clk),
            .en        (en3),
            .cut       (cut_reg[c]),
            .level_reg (level_reg[c])
        );
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {level_reg[ppr_pkg::CHAN_BLUE],
                       level_reg[ppr_pkg::CHAN_GREEN],
                       level_reg[ppr_pkg::CHAN_RED]};

`ifndef SYNTHESIS
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v3_reg |-> s_tready)
        else $error("input not ready while output stage empty");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !m_tready) |-> !s_tready)
        else $error("input accepted into a full stalled pipeline");

    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer missing from stage 1");

    a_mid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3) |=> v3_reg)
        else $error("stage 2 item lost on advance");
`endif

endmodule

@@ hdl/ppr_chan_sel.sv @@
`timescale 1ns / 1ps
// Stage 1: byte masking of the pixel and choice of each channel's field.
// Depends on ppr_pkg.
module ppr_chan_sel
(
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         pixel_word,
    input  ppr_pkg::cfg_t       cfg,
    output logic [31:0]         word_reg,
    output ppr_pkg::chan_t      chan_reg [ppr_pkg::NUM_CHAN]
);

    logic [31:0]    word_next;
    ppr_pkg::chan_t chan_next [ppr_pkg::NUM_CHAN];
    logic           any_len;

    function automatic ppr_pkg::chan_t make_chan(input logic [5:0] off, input logic [4:0] len);
        ppr_pkg::chan_t c;
        c.zero   = (len == 5'd0) || (len > ppr_pkg::MAX_LENGTH) || off[5];
        c.offset = off[4:0];
        c.length = len;
        return c;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            word_next[8*i +: 8] = (cfg.pixel_size_bytes > 3'(i)) ? pixel_word[8*i +: 8] : 8'd0;
        end
    end

    assign any_len = |{cfg.red_length, cfg.green_length, cfg.blue_length};

    always_comb
    begin
        if (any_len)
        begin
            chan_next[ppr_pkg::CHAN_RED]   = make_chan(cfg.red_offset, cfg.red_length);
            chan_next[ppr_pkg::CHAN_GREEN] = make_chan(cfg.green_offset, cfg.green_length);
            chan_next[ppr_pkg::CHAN_BLUE]  = make_chan(cfg.blue_offset, cfg.blue_length);
        end
        else if (cfg.pixel_size_bytes == ppr_pkg::RGB565_BYTES)
        begin
            chan_next[ppr_pkg::CHAN_RED]   = make_chan({1'b0, ppr_pkg::RGB565_RED_OFF},
                                                       ppr_pkg::RGB565_RED_LEN);
            chan_next[ppr_pkg::CHAN_GREEN] = make_chan({1'b0, ppr_pkg::RGB565_GREEN_OFF},
                                                       ppr_pkg::RGB565_GREEN_LEN);
            chan_next[ppr_pkg::CHAN_BLUE]  = make_chan({1'b0, ppr_pkg::RGB565_BLUE_OFF},
                                                       ppr_pkg::RGB565_BLUE_LEN);
        end
        else
        begin
            chan_next[ppr_pkg::CHAN_RED]   = make_chan({1'b0, ppr_pkg::XRGB_RED_OFF},
                                                       ppr_pkg::XRGB_LEN);
            chan_next[ppr_pkg::CHAN_GREEN] = make_chan({1'b0, ppr_pkg::XRGB_GREEN_OFF},
                                                       ppr_pkg::XRGB_LEN);
            chan_next[ppr_pkg::CHAN_BLUE]  = make_chan({1'b0, ppr_pkg::XRGB_BLUE_OFF},
                                                       ppr_pkg::XRGB_LEN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
            for (int c = 0; c < ppr_pkg::NUM_CHAN; c++)
            begin
                chan_reg[c] <= chan_next[c];
            end
        end
    end

endmodule

@@ hdl/ppr_field_cut.sv @@
`timescale 1ns / 1ps
// Stage 2: shift one channel's field down and mask it to its length.
// Depends on ppr_pkg.
module ppr_field_cut
(
    input  logic           clk,
    input  logic           en,
    input  logic [31:0]    word,
    input  ppr_pkg::chan_t chan,
    output ppr_pkg::cut_t  cut_reg
);

    ppr_pkg::cut_t cut_next;
    logic [31:0]   shifted;
    logic [16:0]   mask;

    assign shifted = word >> chan.offset;
    assign mask    = (17'd1 << chan.length) - 17'd1;

    always_comb
    begin
        cut_next.zero   = chan.zero;
        cut_next.length = chan.length;
        cut_next.value  = chan.zero ? 16'd0 : (shifted[15:0] & mask[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cut_reg <= cut_next;
        end
    end

endmodule

@@ hdl/ppr_widen.sv @@
`timescale 1ns / 1ps
// Stage 3: bring one channel's field to eight bits and hold it for output.
// Depends on ppr_pkg.
module ppr_widen
(
    input  logic          clk,
    input  logic          en,
    input  ppr_pkg::cut_t cut,
    output logic [7:0]    level_reg
);

    logic [7:0] level_next;
    logic [3:0] drop;

    // Repeat the high bits of a short field into the low ones
    function automatic logic [7:0] replicate(input logic [6:0] v, input logic [2:0] len);
        logic [7:0] r;
        case (len)
            3'd1:    r = {8{v[0]}};
            3'd2:    r = {4{v[1:0]}};
            3'd3:    r = {v[2:0], v[2:0], v[2:1]};
            3'd4:    r = {2{v[3:0]}};
            3'd5:    r = {v[4:0], v[4:2]};
            3'd6:    r = {v[5:0], v[5:4]};
            3'd7:    r = {v[6:0], v[6]};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    assign drop = 4'(cut.length - 5'd8);

    always_comb
    begin
        if (cut.zero)
        begin
            level_next = 8'd0;
        end
        else if (cut.length >= 5'd8)
        begin
            level_next = 8'(cut.value >> drop);
        end
        else
        begin
            level_next = replicate(cut.value[6:0], cut.length[2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= level_next;
        end
    end

endmodule
